### rtl/kdsr_pkg.sv
// Shared types, constants and helpers for the keypad debounce and SOCD resolver.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package kdsr_pkg;

    localparam int KEY_COUNT      = 6;
    localparam int PAIR_COUNT_MAX = 2;
    localparam int KEY_W          = 3;
    localparam int KIND_W         = 2;
    localparam int TIME_W         = 32;
    localparam int DEB_W          = 8;
    localparam int MODES_W        = 2 * KEY_COUNT;
    localparam int PCOUNT_W       = 2;

    localparam int S_DATA_W = ((TIME_W + KEY_COUNT + 7) / 8) * 8;
    localparam int M_DATA_W = ((KEY_W + 7) / 8) * 8;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    // slot layout: two per key for debounce events, one per key for plain follow,
    // two per pair for pair resolution
    localparam int DEB_SLOTS   = 2 * KEY_COUNT;
    localparam int FOLLOW_BASE = DEB_SLOTS;
    localparam int PAIR_BASE   = 3 * KEY_COUNT;
    localparam int NSLOT       = 3 * KEY_COUNT + 2 * PAIR_COUNT_MAX;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 8'd5;

    localparam logic [1:0] MODE_PLAIN  = 2'd0;
    localparam logic [1:0] MODE_DUAL   = 2'd1;
    localparam logic [1:0] MODE_MACRO  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [KIND_W-1:0] EV_PRESS   = 2'd0;
    localparam logic [KIND_W-1:0] EV_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] EV_ALT     = 2'd2;
    localparam logic [KIND_W-1:0] EV_MACRO   = 2'd3;

    localparam logic [2:0] REG_DEBOUNCE     = 3'd0;
    localparam logic [2:0] REG_KEY_MODES    = 3'd1;
    localparam logic [2:0] REG_ALT_MASK     = 3'd2;
    localparam logic [2:0] REG_PAIR_COUNT   = 3'd3;
    localparam logic [2:0] REG_PAIR0_FIRST  = 3'd4;
    localparam logic [2:0] REG_PAIR0_SECOND = 3'd5;
    localparam logic [2:0] REG_PAIR1_FIRST  = 3'd6;
    localparam logic [2:0] REG_PAIR1_SECOND = 3'd7;

    typedef struct packed {
        logic [KEY_W-1:0]  key_index;
        logic [KIND_W-1:0] event_kind;
    } ev_t;

    localparam int EV_W = KEY_W + KIND_W;

    typedef struct packed {
        logic [NSLOT-1:0]      valid;
        ev_t  [NSLOT-1:0]      ev;
    } entry_t;

    typedef struct packed {
        logic [DEB_W-1:0]                     debounce_ms;
        logic [MODES_W-1:0]                   key_modes;
        logic [KEY_COUNT-1:0]                 alt_key_mask;
        logic [PCOUNT_W-1:0]                  pair_count;
        logic [PAIR_COUNT_MAX-1:0][KEY_W-1:0] pair_first;
        logic [PAIR_COUNT_MAX-1:0][KEY_W-1:0] pair_second;
    } cfg_t;

    // mode code three behaves as plain
    function automatic logic [1:0] mode_of(input logic [MODES_W-1:0] modes, input int k);
        logic [1:0] m;
        m = modes[2*k +: 2];
        return (m == MODE_UNUSED) ? MODE_PLAIN : m;
    endfunction

endpackage

`default_nettype wire

### rtl/keypad_debounce_socd_resolver_top.sv
// Path: a sample passes the middle stage, the queue, the back end's entry register
// and the single output register before its first event leaves. Throughput: one
// sample beat per cycle while the two-entry queue has room; the back end sends one
// event beat per cycle while the output is not stalled, up to twelve per sample.
// Reset: synchronous, active low; restores register defaults, all levels high,
// no key active, stamps and change times zero.
`default_nettype none

module keypad_debounce_socd_resolver_top import kdsr_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_DATA_W-1:0]   s_tdata,   // now_ms[31:0], raw_levels[37:32], zero
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [M_DATA_W-1:0]   m_tdata,   // key_index[2:0], zero
    output logic      [KIND_W-1:0]     m_tuser,   // event_kind[1:0]
    output logic                       m_tlast
);

    cfg_t cfg_reg, cfg_next;
    logic [2:0] reg_idx;
    logic wr_en;
    logic q_full, q_empty, push, pop;
    entry_t push_entry, pop_entry;
    ev_t out_ev;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_DEBOUNCE:     cfg_next.debounce_ms    = pwdata[DEB_W-1:0];
                REG_KEY_MODES:    cfg_next.key_modes      = pwdata[MODES_W-1:0];
                REG_ALT_MASK:     cfg_next.alt_key_mask   = pwdata[KEY_COUNT-1:0];
                REG_PAIR_COUNT:   cfg_next.pair_count     = pwdata[PCOUNT_W-1:0];
                REG_PAIR0_FIRST:  cfg_next.pair_first[0]  = pwdata[KEY_W-1:0];
                REG_PAIR0_SECOND: cfg_next.pair_second[0] = pwdata[KEY_W-1:0];
                REG_PAIR1_FIRST:  cfg_next.pair_first[1]  = pwdata[KEY_W-1:0];
                REG_PAIR1_SECOND: cfg_next.pair_second[1] = pwdata[KEY_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_DEBOUNCE:     prdata = CFG_DATA_W'(cfg_reg.debounce_ms);
            REG_KEY_MODES:    prdata = CFG_DATA_W'(cfg_reg.key_modes);
            REG_ALT_MASK:     prdata = CFG_DATA_W'(cfg_reg.alt_key_mask);
            REG_PAIR_COUNT:   prdata = CFG_DATA_W'(cfg_reg.pair_count);
            REG_PAIR0_FIRST:  prdata = CFG_DATA_W'(cfg_reg.pair_first[0]);
            REG_PAIR0_SECOND: prdata = CFG_DATA_W'(cfg_reg.pair_second[0]);
            REG_PAIR1_FIRST:  prdata = CFG_DATA_W'(cfg_reg.pair_first[1]);
            REG_PAIR1_SECOND: prdata = CFG_DATA_W'(cfg_reg.pair_second[1]);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= {DEBOUNCE_RESET, {($bits(cfg_t) - DEB_W){1'b0}}};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    kdsr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    kdsr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .empty      (q_empty)
    );

    kdsr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_entry   (pop_entry),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_ev    (out_ev),
        .out_last  (m_tlast)
    );

    assign m_tdata = M_DATA_W'(out_ev.key_index);
    assign m_tuser = out_ev.event_kind;

endmodule

`default_nettype wire

### rtl/kdsr_front.sv
// Front end: debounces each accepted sample, then resolves plain keys and pairs
// into one entry of event slots per sample. Depends on kdsr_pkg.
`default_nettype none

module kdsr_front import kdsr_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire cfg_t                cfg,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic                q_full,
    output logic                     push,
    output entry_t                   push_entry
);

    logic [KEY_COUNT-1:0] prev_reg, prev_next;
    logic [KEY_COUNT-1:0] stable_reg, stable_next;
    logic [KEY_COUNT-1:0] active_reg, active_next;
    logic [KEY_COUNT-1:0][TIME_W-1:0] ctime_reg, ctime_next;
    logic [KEY_COUNT-1:0][TIME_W-1:0] stamp_reg, stamp_next;
    logic [KEY_COUNT-1:0][KEY_COUNT-1:0] ord_eq_reg, ord_eq_next;
    logic [KEY_COUNT-1:0][KEY_COUNT-1:0] ord_lt_reg, ord_lt_next;
    logic mid_valid_reg, mid_valid_next;
    logic [DEB_SLOTS-1:0] mid_vld_reg, mid_vld_next;
    logic [DEB_SLOTS-1:0][KIND_W-1:0] mid_kind_reg, mid_kind_next;

    logic [TIME_W-1:0] now;
    logic [KEY_COUNT-1:0] raw;
    logic accept, mid_go;
    logic [KEY_COUNT-1:0][1:0] mode;
    logic [KEY_COUNT-1:0][TIME_W-1:0] since, now_minus, minus_now;
    logic [KEY_COUNT-1:0] now_eq, acc, pnew, dual_set, dual_clr, plain;
    logic [DEB_SLOTS-1:0] deb_vld;
    logic [DEB_SLOTS-1:0][KIND_W-1:0] deb_kind;

    logic [KEY_COUNT-1:0] act, in_pair;
    logic [PAIR_COUNT_MAX-1:0] pvalid;
    logic [PAIR_COUNT_MAX-1:0][KEY_W-1:0] pa_idx, pb_idx;
    logic pa, pb, wa, wb;
    entry_t ent;

    assign now      = s_tdata[TIME_W-1:0];
    assign raw      = s_tdata[TIME_W +: KEY_COUNT];
    assign mid_go   = mid_valid_reg && !q_full;
    assign s_tready = !mid_valid_reg || !q_full;
    assign accept   = s_tvalid && s_tready;

    // per-key debounce, all keys side by side
    always_comb begin
        for (int k = 0; k < KEY_COUNT; k++) begin
            mode[k]      = mode_of(cfg.key_modes, k);
            plain[k]     = (mode[k] == MODE_PLAIN);
            since[k]     = now - ctime_reg[k];
            now_minus[k] = now - stamp_reg[k];
            minus_now[k] = stamp_reg[k] - now;
            now_eq[k]    = (now == stamp_reg[k]);
            acc[k]       = (raw[k] == prev_reg[k]) && (since[k] > TIME_W'(cfg.debounce_ms))
                           && (raw[k] != stable_reg[k]);
            pnew[k]      = acc[k] && !raw[k];
            dual_set[k]  = acc[k] && (mode[k] == MODE_DUAL) && !raw[k];
            dual_clr[k]  = acc[k] && (mode[k] == MODE_DUAL) && raw[k];

            deb_vld[2*k]    = (pnew[k] && (mode[k] == MODE_MACRO)) || dual_set[k]
                              || (dual_clr[k] && active_reg[k]);
            deb_kind[2*k]   = (mode[k] == MODE_MACRO) ? EV_MACRO
                              : (raw[k] ? EV_RELEASE : EV_PRESS);
            deb_vld[2*k+1]  = dual_clr[k] && cfg.alt_key_mask[k];
            deb_kind[2*k+1] = EV_ALT;
        end
    end

    always_comb begin
        prev_next      = prev_reg;
        stable_next    = stable_reg;
        ctime_next     = ctime_reg;
        stamp_next     = stamp_reg;
        ord_eq_next    = ord_eq_reg;
        ord_lt_next    = ord_lt_reg;
        mid_vld_next   = mid_vld_reg;
        mid_kind_next  = mid_kind_reg;
        mid_valid_next = mid_valid_reg;
        if (s_tready) begin
            mid_valid_next = s_tvalid;
        end
        if (accept) begin
            prev_next     = raw;
            mid_vld_next  = deb_vld;
            mid_kind_next = deb_kind;
            for (int k = 0; k < KEY_COUNT; k++) begin
                if (raw[k] != prev_reg[k]) begin
                    ctime_next[k] = now;
                end
                if (acc[k]) begin
                    stable_next[k] = raw[k];
                end
                if (pnew[k]) begin
                    stamp_next[k] = now;
                end
            end
            // keep press order relations in step with the stamps
            for (int a = 0; a < KEY_COUNT; a++) begin
                for (int b = 0; b < KEY_COUNT; b++) begin
                    if (pnew[a] && pnew[b]) begin
                        ord_eq_next[a][b] = 1'b1;
                        ord_lt_next[a][b] = 1'b0;
                    end else if (pnew[a]) begin
                        ord_eq_next[a][b] = now_eq[b];
                        ord_lt_next[a][b] = !now_eq[b] && !now_minus[b][TIME_W-1];
                    end else if (pnew[b]) begin
                        ord_eq_next[a][b] = now_eq[a];
                        ord_lt_next[a][b] = !now_eq[a] && !minus_now[a][TIME_W-1];
                    end
                end
            end
        end
    end

    // resolve plain keys and pairs for the sample held in the middle stage
    always_comb begin
        ent = '0;
        act = active_reg;
        in_pair = '0;
        pa = 1'b0;
        pb = 1'b0;
        wa = 1'b0;
        wb = 1'b0;
        for (int p = 0; p < PAIR_COUNT_MAX; p++) begin
            pa_idx[p] = cfg.pair_first[p];
            pb_idx[p] = cfg.pair_second[p];
            pvalid[p] = (cfg.pair_count > PCOUNT_W'(p))
                        && (32'(pa_idx[p]) < KEY_COUNT) && (32'(pb_idx[p]) < KEY_COUNT)
                        && (pa_idx[p] != pb_idx[p]);
            if (pvalid[p]) begin
                pvalid[p] = plain[pa_idx[p]] && plain[pb_idx[p]];
            end
            if (pvalid[p]) begin
                in_pair[pa_idx[p]] = 1'b1;
                in_pair[pb_idx[p]] = 1'b1;
            end
        end

        for (int k = 0; k < KEY_COUNT; k++) begin
            ent.valid[2*k]               = mid_vld_reg[2*k];
            ent.ev[2*k].key_index        = KEY_W'(k);
            ent.ev[2*k].event_kind       = mid_kind_reg[2*k];
            ent.valid[2*k+1]             = mid_vld_reg[2*k+1];
            ent.ev[2*k+1].key_index      = KEY_W'(k);
            ent.ev[2*k+1].event_kind     = mid_kind_reg[2*k+1];
        end

        for (int k = 0; k < KEY_COUNT; k++) begin
            ent.ev[FOLLOW_BASE+k].key_index = KEY_W'(k);
            if (plain[k] && !in_pair[k]) begin
                if (!stable_reg[k] && !act[k]) begin
                    ent.valid[FOLLOW_BASE+k]         = 1'b1;
                    ent.ev[FOLLOW_BASE+k].event_kind = EV_PRESS;
                    act[k] = 1'b1;
                end else if (stable_reg[k] && act[k]) begin
                    ent.valid[FOLLOW_BASE+k]         = 1'b1;
                    ent.ev[FOLLOW_BASE+k].event_kind = EV_RELEASE;
                    act[k] = 1'b0;
                end
            end
        end

        for (int p = 0; p < PAIR_COUNT_MAX; p++) begin
            ent.ev[PAIR_BASE+2*p].key_index   = pa_idx[p];
            ent.ev[PAIR_BASE+2*p+1].key_index = pb_idx[p];
            if (pvalid[p]) begin
                pa = !stable_reg[pa_idx[p]];
                pb = !stable_reg[pb_idx[p]];
                wa = 1'b0;
                wb = 1'b0;
                if (pa && pb) begin
                    if (ord_eq_reg[pa_idx[p]][pb_idx[p]]) begin
                        if (act[pa_idx[p]]) begin
                            wa = 1'b1;
                        end else if (act[pb_idx[p]]) begin
                            wb = 1'b1;
                        end
                    end else if (ord_lt_reg[pa_idx[p]][pb_idx[p]]) begin
                        wa = 1'b1;
                    end else begin
                        wb = 1'b1;
                    end
                end else begin
                    wa = pa;
                    wb = pb;
                end
                if (wa != act[pa_idx[p]]) begin
                    ent.valid[PAIR_BASE+2*p]         = 1'b1;
                    ent.ev[PAIR_BASE+2*p].event_kind = wa ? EV_PRESS : EV_RELEASE;
                    act[pa_idx[p]] = wa;
                end
                if (wb != act[pb_idx[p]]) begin
                    ent.valid[PAIR_BASE+2*p+1]         = 1'b1;
                    ent.ev[PAIR_BASE+2*p+1].event_kind = wb ? EV_PRESS : EV_RELEASE;
                    act[pb_idx[p]] = wb;
                end
            end
        end
    end

    // dual keys are owned by the debounce stage, plain keys by resolution
    always_comb begin
        active_next = active_reg;
        if (mid_go) begin
            active_next = act;
        end
        if (accept) begin
            active_next = (active_next | dual_set) & ~dual_clr;
        end
    end

    assign push       = mid_go && (ent.valid != '0);
    assign push_entry = ent;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg      <= '1;
            stable_reg    <= '1;
            active_reg    <= '0;
            ctime_reg     <= '0;
            stamp_reg     <= '0;
            ord_eq_reg    <= '1;
            ord_lt_reg    <= '0;
            mid_valid_reg <= 1'b0;
        end else begin
            prev_reg      <= prev_next;
            stable_reg    <= stable_next;
            active_reg    <= active_next;
            ctime_reg     <= ctime_next;
            stamp_reg     <= stamp_next;
            ord_eq_reg    <= ord_eq_next;
            ord_lt_reg    <= ord_lt_next;
            mid_valid_reg <= mid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mid_vld_reg  <= mid_vld_next;
        mid_kind_reg <= mid_kind_next;
    end

endmodule

`default_nettype wire

### rtl/kdsr_queue.sv
// Short register queue of event entries between front and back end.
// Depends on kdsr_pkg.
`default_nettype none

module kdsr_queue import kdsr_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   push,
    input  wire entry_t push_entry,
    output logic        full,
    input  wire logic   pop,
    output entry_t      pop_entry,
    output logic        empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign pop_entry = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

### rtl/kdsr_back.sv
// Back end: takes entries from the queue and sends their events one beat at a
// time through an output register. Depends on kdsr_pkg.
`default_nettype none

module kdsr_back import kdsr_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   q_empty,
    input  wire entry_t q_entry,
    output logic        pop,
    output logic        out_valid,
    input  wire logic   out_ready,
    output ev_t         out_ev,
    output logic        out_last
);

    logic cur_valid_reg, cur_valid_next;
    logic [NSLOT-1:0] cur_mask_reg, cur_mask_next;
    ev_t [NSLOT-1:0] cur_ev_reg, cur_ev_next;
    logic out_valid_reg, out_valid_next;
    ev_t out_ev_reg, out_ev_next;
    logic out_last_reg, out_last_next;

    logic [NSLOT-1:0] pick, rest;
    logic [EV_W-1:0] sel_ev;
    logic out_free, fire, done, load;

    always_comb begin
        pick   = cur_mask_reg & (~cur_mask_reg + 1'b1);
        rest   = cur_mask_reg & ~pick;
        sel_ev = '0;
        for (int i = 0; i < NSLOT; i++) begin
            if (pick[i]) begin
                sel_ev = sel_ev | cur_ev_reg[i];
            end
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    assign fire     = cur_valid_reg && out_free;
    assign done     = fire && (rest == '0);
    assign load     = !q_empty && (!cur_valid_reg || done);
    assign pop      = load;

    always_comb begin
        cur_valid_next = cur_valid_reg;
        cur_mask_next  = cur_mask_reg;
        cur_ev_next    = cur_ev_reg;
        out_valid_next = out_valid_reg;
        out_ev_next    = out_ev_reg;
        out_last_next  = out_last_reg;
        if (fire) begin
            out_valid_next = 1'b1;
            out_ev_next    = sel_ev;
            out_last_next  = (rest == '0);
            cur_mask_next  = rest;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
        if (done) begin
            cur_valid_next = 1'b0;
        end
        if (load) begin
            cur_valid_next = 1'b1;
            cur_mask_next  = q_entry.valid;
            cur_ev_next    = q_entry.ev;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_mask_reg <= cur_mask_next;
        cur_ev_reg   <= cur_ev_next;
        out_ev_reg   <= out_ev_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_ev    = out_ev_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

### rtl/kdsr_checker.sv
// Port-level checks for the keypad resolver top level, bound to it below.
// Depends on kdsr_pkg.
`default_nettype none

module kdsr_checker import kdsr_pkg::*; (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_tready,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata,
    input wire logic [KIND_W-1:0]   m_tuser,
    input wire logic                m_tlast
);

    // hold a stalled beat
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result beat changed while stalled");

    a_key_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (32'(m_tdata) < KEY_COUNT))
        else $error("event key index out of range");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat right after reset");

    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready right after reset");

endmodule

bind keypad_debounce_socd_resolver_top kdsr_checker u_kdsr_checker (.*);

`default_nettype wire
